// ----- design/deq_pkg.sv -----
// Shared types and constants for the double-ended queue.
`default_nettype none
package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;

  // Result of a pop on an empty queue
  localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4
  } op_t;

endpackage
`default_nettype wire

// ----- design/deq_ram.sv -----
// Entry store: one write port, one read port with registered read data.
`default_nettype none
module deq_ram #(
  parameter int DEPTH  = deq_pkg::DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [ADDR_W-1:0]           wr_addr,
  input  wire logic [deq_pkg::DATA_W-1:0]  wr_data,
  input  wire logic                        rd_en,
  input  wire logic [ADDR_W-1:0]           rd_addr,
  output logic      [deq_pkg::DATA_W-1:0]  rd_data
);

  logic [deq_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- design/double_ended_queue.sv -----
// Double-ended queue: ring buffer in a synchronous memory, front/back pointers and count.
// Pipeline: an accepted transaction passes through the entry store read and then
//   the output register before its result is valid.
// Throughput: one transaction per cycle unless the output is stalled; pointers and count
//   update at acceptance, so back-to-back requests never wait on the memory read.
// Reset: pointers and count return to zero; the entry store is not cleared.
`default_nettype none
module double_ended_queue #(
  parameter int DEPTH  = deq_pkg::DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int CNT_W  = $clog2(DEPTH + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [deq_pkg::OP_W-1:0]          in_op,
  input  wire logic signed [deq_pkg::DATA_W-1:0] in_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [deq_pkg::DATA_W-1:0]      out_popped_value,
  output logic                                   out_empty_error,
  output logic                                   out_full_error,
  output logic      [CNT_W-1:0]                  out_item_count
);

  typedef struct packed {
    logic             pop;
    logic             empty_err;
    logic             full_err;
    logic [CNT_W-1:0] count;
  } s1_info_t;

  logic [ADDR_W-1:0] front_r, front_nxt;
  logic [ADDR_W-1:0] back_r, back_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              s1_vld_r, s1_vld_nxt;
  s1_info_t          s1_r, s1_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [deq_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_empty_r, out_full_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic              in_acc, s1_move, out_take;
  logic              is_full, is_empty;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [ADDR_W-1:0] front_inc, front_dec, back_inc, back_dec;
  logic [deq_pkg::DATA_W-1:0] rd_data;

  function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + ADDR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_dec(input logic [ADDR_W-1:0] p);
    return (p == '0) ? ADDR_W'(DEPTH - 1) : p - ADDR_W'(1);
  endfunction

  // Handshake: s1 advances into the output register whenever that is free
  assign out_take = out_vld_r && !out_stall;
  assign s1_move  = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_move;
  assign in_acc   = in_valid && !in_stall;

  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign front_inc = slot_inc(front_r);
  assign front_dec = slot_dec(front_r);
  assign back_inc  = slot_inc(back_r);
  assign back_dec  = slot_dec(back_r);

  // Pointer, count and memory access for the accepted transaction
  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = back_r;
    rd_en     = 1'b0;
    rd_addr   = front_r;
    s1_nxt    = '{pop: 1'b0, empty_err: 1'b0, full_err: 1'b0, count: count_r};
    if (in_acc) begin
      unique case (deq_pkg::op_t'(in_op))
        deq_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            s1_nxt.full_err = 1'b1;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = back_r;
            back_nxt  = back_inc;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        deq_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            s1_nxt.full_err = 1'b1;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = front_dec;
            front_nxt = front_dec;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (is_empty) begin
            s1_nxt.empty_err = 1'b1;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = front_r;
            front_nxt  = front_inc;
            count_nxt  = count_r - CNT_W'(1);
            s1_nxt.pop = 1'b1;
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (is_empty) begin
            s1_nxt.empty_err = 1'b1;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = back_dec;
            back_nxt   = back_dec;
            count_nxt  = count_r - CNT_W'(1);
            s1_nxt.pop = 1'b1;
          end
        end
        deq_pkg::OP_CLEAR: begin
          front_nxt = '0;
          back_nxt  = '0;
          count_nxt = '0;
        end
        default: begin
        end
      endcase
      s1_nxt.count = count_nxt;
    end
  end

  deq_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (deq_pkg::DATA_W'(in_value)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    priority if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_move) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end

    priority if (s1_move) begin
      out_vld_nxt = 1'b1;
    end else if (out_take) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end

    priority if (s1_r.pop) begin
      out_data_nxt = rd_data;
    end else if (s1_r.empty_err) begin
      out_data_nxt = deq_pkg::INT_MAX;
    end else begin
      out_data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r   <= '0;
      back_r    <= '0;
      count_r   <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      front_r   <= front_nxt;
      back_r    <= back_nxt;
      count_r   <= count_nxt;
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_move) begin
      out_data_r  <= out_data_nxt;
      out_empty_r <= s1_r.empty_err;
      out_full_r  <= s1_r.full_err;
      out_cnt_r   <= s1_r.count;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_popped_value = out_data_r;
  assign out_empty_error  = out_empty_r;
  assign out_full_error   = out_full_r;
  assign out_item_count   = out_cnt_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_W'(DEPTH)) |-> front_r == back_r)
    else $error("pointers disagree with empty or full count");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> !in_stall)
    else $error("input stalled with read stage empty");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_empty_r && out_full_r))
    else $error("empty and full errors on one transaction");

endmodule
`default_nettype wire
